/* design/json_array_element_extractor_assert.svh */
// Assertion helpers for the JSON array element extractor.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef JSON_ARRAY_ELEMENT_EXTRACTOR_ASSERT_SVH
`define JSON_ARRAY_ELEMENT_EXTRACTOR_ASSERT_SVH

// Same-cycle implication.
`define JAEE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JAEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/jaee_pkg.sv */
`default_nettype none

package jaee_pkg;

  localparam int unsigned IndexBitsDef = 16;
  localparam int unsigned DepthBitsDef = 8;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned CountW       = 16;
  localparam int unsigned TargetW      = 16;
  localparam int unsigned OutDataW     = 32;

  localparam logic [ByteW-1:0] ChLBrack = 8'h5B;  // [
  localparam logic [ByteW-1:0] ChRBrack = 8'h5D;  // ]
  localparam logic [ByteW-1:0] ChLBrace = 8'h7B;  // {
  localparam logic [ByteW-1:0] ChRBrace = 8'h7D;  // }
  localparam logic [ByteW-1:0] ChComma  = 8'h2C;
  localparam logic [ByteW-1:0] ChQuote  = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_BETWEEN,
    PH_STRING,
    PH_BRACKET,
    PH_SCALAR,
    PH_CLOSED,
    PH_NOTARRAY
  } phase_e;

  // One result word, before packing onto the output bus.
  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic              out_valid;
    logic              done_res;
    logic [CountW-1:0] element_count;
    logic              found;
    logic              not_array;
    logic              unterminated;
  } result_t;

  function automatic logic is_ws(input logic [ByteW-1:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
  endfunction

endpackage

`default_nettype wire

/* design/jaee_in_stage.sv */
`default_nettype none

module jaee_in_stage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_valid_i,
  output logic                             s_ready_o,
  input  wire logic [jaee_pkg::ByteW-1:0]  s_byte_i,
  input  wire logic                        s_last_i,
  input  wire logic                        load_ok_i,
  output logic                             step_o,
  output logic [jaee_pkg::ByteW-1:0]       byte_o,
  output logic                             last_o
);

  logic                       vld_q;
  logic [jaee_pkg::ByteW-1:0] byte_q;
  logic                       last_q;

  assign s_ready_o = !vld_q || load_ok_i;
  assign step_o    = vld_q && load_ok_i;
  assign byte_o    = byte_q;
  assign last_o    = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_ready_o) begin
      vld_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      byte_q <= s_byte_i;
      last_q <= s_last_i;
    end
  end

endmodule

`default_nettype wire

/* design/jaee_core.sv */
`default_nettype none

module jaee_core #(
  parameter int unsigned INDEX_BITS = jaee_pkg::IndexBitsDef,
  parameter int unsigned DEPTH_BITS = jaee_pkg::DepthBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [jaee_pkg::ByteW-1:0]    byte_i,
  input  wire logic                          last_i,
  input  wire logic [jaee_pkg::TargetW-1:0]  target_i,
  output jaee_pkg::result_t                  res_o
);

  jaee_pkg::phase_e        phase_q, phase_d;
  logic                    kind_q, kind_d;        // 1: array, 0: object
  logic [DEPTH_BITS-1:0]   depth_q, depth_d;
  logic                    inner_q, inner_d;
  logic                    esc_q, esc_d;
  logic [INDEX_BITS-1:0]   seen_q, seen_d;
  logic                    active_q, active_d;
  logic                    sel_seen_q, sel_seen_d;

  logic                    ws, sep, begins, sel, emit;
  logic [jaee_pkg::ByteW-1:0] open_ch, close_ch;
  logic [DEPTH_BITS-1:0]   depth_dec;
  logic [INDEX_BITS-1:0]   tgt;
  logic [jaee_pkg::CountW-1:0] count;

  assign ws      = jaee_pkg::is_ws(byte_i);
  assign sep     = ws || (byte_i == jaee_pkg::ChComma) || (byte_i == jaee_pkg::ChRBrace);
  assign begins  = !sep && (byte_i != jaee_pkg::ChRBrack);
  assign tgt     = INDEX_BITS'(target_i);
  assign sel     = !sel_seen_q && (seen_q == tgt);
  assign open_ch  = kind_q ? jaee_pkg::ChLBrack : jaee_pkg::ChLBrace;
  assign close_ch = kind_q ? jaee_pkg::ChRBrack : jaee_pkg::ChRBrace;
  assign depth_dec = (depth_q != '0) ? depth_q - 1'b1 : depth_q;

  // Next state
  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    depth_d    = depth_q;
    inner_d    = inner_q;
    esc_d      = esc_q;
    seen_d     = seen_q;
    active_d   = active_q;
    sel_seen_d = sel_seen_q;
    case (phase_q)
      jaee_pkg::PH_LEAD: begin
        if (!ws) begin
          phase_d = (byte_i == jaee_pkg::ChLBrack) ? jaee_pkg::PH_BETWEEN
                                                  : jaee_pkg::PH_NOTARRAY;
        end
      end
      jaee_pkg::PH_BETWEEN: begin
        if (byte_i == jaee_pkg::ChRBrack && !sep) begin
          phase_d = jaee_pkg::PH_CLOSED;
        end else if (begins) begin
          active_d = sel;
          if (sel) begin
            sel_seen_d = 1'b1;
          end
          if (seen_q != '1) begin
            seen_d = seen_q + 1'b1;
          end
          inner_d = 1'b0;
          esc_d   = 1'b0;
          if (byte_i == jaee_pkg::ChQuote) begin
            phase_d = jaee_pkg::PH_STRING;
          end else if (byte_i == jaee_pkg::ChLBrace || byte_i == jaee_pkg::ChLBrack) begin
            phase_d = jaee_pkg::PH_BRACKET;
            kind_d  = (byte_i == jaee_pkg::ChLBrack);
            depth_d = DEPTH_BITS'(1);
          end else begin
            phase_d = jaee_pkg::PH_SCALAR;
          end
        end
      end
      jaee_pkg::PH_STRING: begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (byte_i == jaee_pkg::ChBslash) begin
          esc_d = 1'b1;
        end else if (byte_i == jaee_pkg::ChQuote) begin
          phase_d  = jaee_pkg::PH_BETWEEN;
          active_d = 1'b0;
        end
      end
      jaee_pkg::PH_BRACKET: begin
        if (inner_q) begin
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (byte_i == jaee_pkg::ChBslash) begin
            esc_d = 1'b1;
          end else if (byte_i == jaee_pkg::ChQuote) begin
            inner_d = 1'b0;
          end
        end else if (byte_i == jaee_pkg::ChQuote) begin
          inner_d = 1'b1;
        end else if (byte_i == open_ch) begin
          if (depth_q != '1) begin
            depth_d = depth_q + 1'b1;
          end
        end else if (byte_i == close_ch) begin
          depth_d = depth_dec;
          if (depth_dec == '0) begin
            phase_d  = jaee_pkg::PH_BETWEEN;
            active_d = 1'b0;
          end
        end
      end
      jaee_pkg::PH_SCALAR: begin
        if (sep) begin
          phase_d  = jaee_pkg::PH_BETWEEN;
          active_d = 1'b0;
        end else if (byte_i == jaee_pkg::ChRBrack) begin
          phase_d  = jaee_pkg::PH_CLOSED;
          active_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Pass-out decision
  always_comb begin
    case (phase_q)
      jaee_pkg::PH_BETWEEN: emit = begins && sel && (byte_i != jaee_pkg::ChQuote);
      jaee_pkg::PH_STRING:  emit = active_q && (esc_q || byte_i != jaee_pkg::ChQuote);
      jaee_pkg::PH_BRACKET: emit = active_q;
      jaee_pkg::PH_SCALAR:  emit = active_q && begins;
      default:              emit = 1'b0;
    endcase
  end

  // Count reported clamped to 16 bits
  if (INDEX_BITS > jaee_pkg::CountW) begin : g_clamp
    assign count = (|seen_d[INDEX_BITS-1:jaee_pkg::CountW]) ? '1
                                                            : seen_d[jaee_pkg::CountW-1:0];
  end else begin : g_wide
    assign count = jaee_pkg::CountW'(seen_d);
  end

  always_comb begin
    res_o.out_byte      = emit ? byte_i : '0;
    res_o.out_valid     = emit;
    res_o.done_res      = last_i;
    res_o.element_count = count;
    res_o.found         = sel_seen_d;
    res_o.not_array     = (phase_d == jaee_pkg::PH_NOTARRAY) ||
                          (last_i && phase_d == jaee_pkg::PH_LEAD);
    res_o.unterminated  = last_i && active_d &&
                          (phase_d == jaee_pkg::PH_STRING ||
                           phase_d == jaee_pkg::PH_BRACKET);
  end

  // Last byte returns the stream state to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= jaee_pkg::PH_LEAD;
      kind_q     <= 1'b0;
      depth_q    <= '0;
      inner_q    <= 1'b0;
      esc_q      <= 1'b0;
      seen_q     <= '0;
      active_q   <= 1'b0;
      sel_seen_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q    <= jaee_pkg::PH_LEAD;
        kind_q     <= 1'b0;
        depth_q    <= '0;
        inner_q    <= 1'b0;
        esc_q      <= 1'b0;
        seen_q     <= '0;
        active_q   <= 1'b0;
        sel_seen_q <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        kind_q     <= kind_d;
        depth_q    <= depth_d;
        inner_q    <= inner_d;
        esc_q      <= esc_d;
        seen_q     <= seen_d;
        active_q   <= active_d;
        sel_seen_q <= sel_seen_d;
      end
    end
  end

endmodule

`default_nettype wire

/* design/jaee_out_stage.sv */
`default_nettype none

module jaee_out_stage (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            step_i,
  input  wire jaee_pkg::result_t               res_i,
  output logic                                 load_ok_o,
  output logic                                 m_valid_o,
  input  wire logic                            m_ready_i,
  output logic [jaee_pkg::OutDataW-1:0]        m_data_o,
  output logic                                 m_user_o,
  output logic                                 m_last_o
);

  logic              vld_q;
  jaee_pkg::result_t res_q;

  assign load_ok_o = !vld_q || m_ready_i;
  assign m_valid_o = vld_q;
  assign m_user_o  = res_q.out_valid;
  assign m_last_o  = res_q.done_res;
  assign m_data_o  = {5'b0, res_q.unterminated, res_q.not_array, res_q.found,
                      res_q.element_count, res_q.out_byte};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= step_i || (vld_q && !m_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

/* design/json_array_element_extractor.sv */
// Channel  Dir  Ports                                  Payload
// s_axis   in   s_axis_tvalid/tready/tdata/tlast       tdata[7:0] in_byte, tlast in_last
// m_axis   out  m_axis_tvalid/tready/tdata/tuser/tlast tdata: out_byte, element_count,
//                                                      found, not_array, unterminated;
//                                                      tuser out_valid, tlast done_res
// cfg      in   cfg_valid_i/cfg_ready_o/cfg_data_i     target_index, 16 bits
//
// One word in and one word out per byte, one byte per cycle sustained while m_axis is not stalled.
// Each byte passes the input register, then the parser state update and
// the result register in the same cycle.
// The parser state loop (phase, nesting depth, element counter) closes through
// its state registers alone, which sets the rate.
// Reset clears the parser state and the valid flags of both registers; target_index resets to 0.
// A stall on m_axis holds the result word and backs up into s_axis after one
// more word has been taken into the input register.
`default_nettype none

module json_array_element_extractor #(
  parameter int unsigned INDEX_BITS = jaee_pkg::IndexBitsDef,
  parameter int unsigned DEPTH_BITS = jaee_pkg::DepthBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // text bytes
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [jaee_pkg::ByteW-1:0]      s_axis_tdata,   // [7:0] in_byte
  input  wire logic                            s_axis_tlast,   // in_last
  // results
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [7:0] out_byte, [23:8] element_count, [24] found, [25] not_array,
  // [26] unterminated, [31:27] zero
  output logic [jaee_pkg::OutDataW-1:0]        m_axis_tdata,
  output logic                                 m_axis_tuser,   // out_valid
  output logic                                 m_axis_tlast,   // done_res
  // target index register
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [jaee_pkg::TargetW-1:0]    cfg_data_i
);

  logic [jaee_pkg::TargetW-1:0] target_q;
  logic                         load_ok;
  logic                         step;
  logic [jaee_pkg::ByteW-1:0]   cur_byte;
  logic                         cur_last;
  jaee_pkg::result_t            res;

  // Register is always writable; the user must write it only while idle, the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_data_i;
    end
  end

  jaee_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_byte_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .load_ok_i (load_ok),
    .step_o    (step),
    .byte_o    (cur_byte),
    .last_o    (cur_last)
  );

  jaee_core #(
    .INDEX_BITS (INDEX_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (cur_byte),
    .last_i   (cur_last),
    .target_i (target_q),
    .res_o    (res)
  );

  jaee_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .res_i     (res),
    .load_ok_o (load_ok),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* design/jaee_checker.sv */
`default_nettype none
`include "json_array_element_extractor_assert.svh"

module jaee_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [jaee_pkg::OutDataW-1:0]     m_axis_tdata,
  input wire logic                              m_axis_tuser,
  input wire logic                              m_axis_tlast
);

  // held word stays put
  `JAEE_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result word changed while stalled")

  // input side only stalls behind a stalled full output
  `JAEE_ASSERT_NOW(a_backpressure, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled with output free")

  // a passed byte belongs to the found element
  `JAEE_ASSERT_NOW(a_emit_found, m_axis_tvalid && m_axis_tuser, m_axis_tdata[24], "byte passed before element found")

  // open-element flag only on the final word
  `JAEE_ASSERT_NOW(a_unterm_last, m_axis_tvalid && m_axis_tdata[26], m_axis_tlast, "unterminated flag on non-final word")

endmodule

bind json_array_element_extractor jaee_checker u_jaee_checker (.*);

`default_nettype wire

/* tb/json_extract_checker.sv */
// Watches the byte, result and target channels of the extractor, predicts one result
// word per accepted byte and compares the words that come out, field by field.
module json_extract_checker
  import jaee_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tuser,
  input  logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [TargetW-1:0]  cfg_data_i,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  emitted_o
);

  localparam logic [DepthBitsDef-1:0] DepthMax = '1;
  localparam logic [IndexBitsDef-1:0] CountMax = '1;

  // parser state as the block should hold it
  phase_e                  cur_phase;
  logic                    nest_is_array;
  logic [DepthBitsDef-1:0] nest_lvl;
  logic                    in_quote;
  logic                    esc_armed;
  logic [IndexBitsDef-1:0] elem_cnt;
  logic                    sel_open;
  logic                    sel_hit;
  logic [TargetW-1:0]      tgt_idx;

  result_t pending_words[$];

  function automatic bit ws_byte(input logic [ByteW-1:0] c);
    return c == ChSpace || c == ChTab || c == ChLf || c == ChCr;
  endfunction

  function automatic void clear_text();
    cur_phase     = PH_LEAD;
    nest_is_array = 1'b0;
    nest_lvl      = '0;
    in_quote      = 1'b0;
    esc_armed     = 1'b0;
    elem_cnt      = '0;
    sel_open      = 1'b0;
    sel_hit       = 1'b0;
  endfunction

  // advances the parser by one byte and returns the word it should produce
  function automatic result_t extract_byte(input logic [ByteW-1:0] c, input logic last);
    result_t r;
    logic    emit;
    emit = 1'b0;
    r    = '0;
    case (cur_phase)
      PH_LEAD: begin
        if (!ws_byte(c)) cur_phase = (c == ChLBrack) ? PH_BETWEEN : PH_NOTARRAY;
      end
      PH_BETWEEN: begin
        // separators and stray closing braces fall through
        if (!(ws_byte(c) || c == ChComma || c == ChRBrace)) begin
          if (c == ChRBrack) begin
            cur_phase = PH_CLOSED;
          end else begin
            sel_open = !sel_hit && (elem_cnt == tgt_idx[IndexBitsDef-1:0]);
            if (sel_open) sel_hit = 1'b1;
            if (elem_cnt != CountMax) elem_cnt++;
            in_quote  = 1'b0;
            esc_armed = 1'b0;
            if (c == ChQuote) begin
              cur_phase = PH_STRING;  // opening quote is dropped
            end else if (c == ChLBrace || c == ChLBrack) begin
              cur_phase     = PH_BRACKET;
              nest_is_array = (c == ChLBrack);
              nest_lvl      = DepthBitsDef'(1);
              emit          = sel_open;
            end else begin
              cur_phase = PH_SCALAR;
              emit      = sel_open;
            end
          end
        end
      end
      PH_STRING: begin
        if (esc_armed) begin
          esc_armed = 1'b0;
          emit      = sel_open;
        end else if (c == ChBslash) begin
          esc_armed = 1'b1;
          emit      = sel_open;
        end else if (c == ChQuote) begin
          cur_phase = PH_BETWEEN;
          sel_open  = 1'b0;
        end else begin
          emit = sel_open;
        end
      end
      PH_BRACKET: begin
        emit = sel_open;
        if (in_quote) begin
          if (esc_armed) esc_armed = 1'b0;
          else if (c == ChBslash) esc_armed = 1'b1;
          else if (c == ChQuote) in_quote = 1'b0;
        end else if (c == ChQuote) begin
          in_quote = 1'b1;
        end else if (c == (nest_is_array ? ChLBrack : ChLBrace)) begin
          if (nest_lvl != DepthMax) nest_lvl++;
        end else if (c == (nest_is_array ? ChRBrack : ChRBrace)) begin
          if (nest_lvl != 0) nest_lvl--;
          if (nest_lvl == 0) begin
            cur_phase = PH_BETWEEN;
            sel_open  = 1'b0;
          end
        end
      end
      PH_SCALAR: begin
        if (ws_byte(c) || c == ChComma || c == ChRBrace) begin
          cur_phase = PH_BETWEEN;
          sel_open  = 1'b0;
        end else if (c == ChRBrack) begin
          cur_phase = PH_CLOSED;
          sel_open  = 1'b0;
        end else begin
          emit = sel_open;
        end
      end
      default: ;
    endcase
    r.out_byte      = emit ? c : '0;
    r.out_valid     = emit;
    r.done_res      = last;
    r.element_count = elem_cnt;
    r.found         = sel_hit;
    r.not_array     = (cur_phase == PH_NOTARRAY) || (last && cur_phase == PH_LEAD);
    r.unterminated  = last && sel_open && (cur_phase == PH_STRING || cur_phase == PH_BRACKET);
    if (last) clear_text();
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("%0t: word %0d field %s: got 0x%0h, expected 0x%0h",
             $time, checked_o, field, got, want);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      clear_text();
      tgt_idx = '0;
      pending_words.delete();
      fail_cnt_o = 0;
      checked_o  = 0;
      emitted_o  = 0;
    end else begin
      // results first: a word leaving now never belongs to a byte entering now
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, 0);
        end else begin
          want = pending_words.pop_front();
          if (m_axis_tdata[7:0] !== want.out_byte)
            report_mismatch("out_byte", m_axis_tdata[7:0], want.out_byte);
          if (m_axis_tuser !== want.out_valid)
            report_mismatch("out_valid", m_axis_tuser, want.out_valid);
          if (m_axis_tlast !== want.done_res)
            report_mismatch("done_res", m_axis_tlast, want.done_res);
          if (m_axis_tdata[23:8] !== want.element_count)
            report_mismatch("element_count", m_axis_tdata[23:8], want.element_count);
          if (m_axis_tdata[24] !== want.found)
            report_mismatch("found", m_axis_tdata[24], want.found);
          if (m_axis_tdata[25] !== want.not_array)
            report_mismatch("not_array", m_axis_tdata[25], want.not_array);
          if (m_axis_tdata[26] !== want.unterminated)
            report_mismatch("unterminated", m_axis_tdata[26], want.unterminated);
          if (m_axis_tdata[31:27] !== 5'd0)
            report_mismatch("pad", m_axis_tdata[31:27], 0);
          if (want.out_valid) emitted_o++;
        end
        checked_o++;
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_words.push_back(extract_byte(s_axis_tdata, s_axis_tlast));
      if (cfg_valid_i && cfg_ready_o) tgt_idx = cfg_data_i;
    end
    pending_o = pending_words.size();
  end

endmodule

/* tb/tb_top.sv */
// Top of the extractor bench: clock, reset, text generation, the two handshake
// drivers and the verdict. All prediction and comparison sits in the checker.
module tb_top;
  import jaee_pkg::*;

  localparam int unsigned PipeLatency = 2;          // input reg + result reg
  localparam int unsigned RandBytes   = 400;        // random text volume
  localparam int unsigned CycleLimit  = 1_500_000;  // hang guard

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata  = '0;   // [7:0] in_byte
  logic                s_axis_tlast  = 1'b0; // in_last
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [7:0] out_byte, [23:8] element_count, [24] found, [25] not_array,
  // [26] unterminated, [31:27] zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;         // out_valid
  logic                m_axis_tlast;         // done_res
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [TargetW-1:0]  cfg_data_i    = '0;

  int fail_cnt;
  int pending;
  int checked;
  int emitted;

  // stimulus bookkeeping
  logic [ByteW-1:0] text_q[$];
  bit               no_idle     = 1'b0;  // both sides run flat out for this text
  int unsigned      hold_cycles = 0;     // one-shot long receiver hold-off
  int unsigned      cycles      = 0;
  int unsigned      n_texts     = 0;
  int unsigned      n_bytes     = 0;
  int unsigned      n_settings  = 0;

  json_array_element_extractor u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  json_extract_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .checked_o     (checked),
    .emitted_o     (emitted)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hang guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result sink. Random stall per word; a requested hold-off is counted here,
  // in this process, while the sender keeps offering bytes and the block backs up.
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (hold_cycles > 0) begin
        stall       = stall + hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  //--------------------------------------------------------------------------
  // Text builders. Everything appends to text_q.
  //--------------------------------------------------------------------------
  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void add_ws(input int unsigned max_n);
    repeat ($urandom_range(0, max_n)) begin
      case ($urandom_range(0, 3))
        0:       text_q.push_back(ChSpace);
        1:       text_q.push_back(ChTab);
        2:       text_q.push_back(ChLf);
        default: text_q.push_back(ChCr);
      endcase
    end
  endfunction

  function automatic logic [ByteW-1:0] rand_byte_except(input logic [ByteW-1:0] a,
                                                        input logic [ByteW-1:0] b,
                                                        input logic [ByteW-1:0] c);
    logic [ByteW-1:0] v;
    v = ByteW'($urandom_range(0, 255));
    while (v == a || v == b || v == c) v = ByteW'($urandom_range(0, 255));
    return v;
  endfunction

  function automatic bit scalar_stop(input logic [ByteW-1:0] b);
    return b == ChSpace || b == ChTab || b == ChLf || b == ChCr ||
           b == ChComma || b == ChRBrace || b == ChRBrack;
  endfunction

  // quoted string, full byte range inside, escapes may hide a quote
  function automatic void add_string();
    text_q.push_back(ChQuote);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 4) == 0) begin
        text_q.push_back(ChBslash);
        text_q.push_back(ByteW'($urandom_range(0, 255)));
      end else begin
        text_q.push_back(rand_byte_except(ChQuote, ChBslash, ChBslash));
      end
    end
    text_q.push_back(ChQuote);
  endfunction

  function automatic void add_scalar();
    logic [ByteW-1:0] b;
    int unsigned      len;
    len = $urandom_range(1, 4);
    for (int k = 0; k < len; k++) begin
      b = ByteW'($urandom_range(0, 255));
      while (scalar_stop(b) || (k == 0 && (b == ChQuote || b == ChLBrack || b == ChLBrace)))
        b = ByteW'($urandom_range(0, 255));
      text_q.push_back(b);
    end
  endfunction

  // balanced object or array; brackets of the other kind and quoted brackets
  // must not disturb the nesting
  function automatic void add_bracket(input bit is_array, input int unsigned lvl);
    logic [ByteW-1:0] open_c;
    logic [ByteW-1:0] close_c;
    open_c  = is_array ? ChLBrack : ChLBrace;
    close_c = is_array ? ChRBrack : ChRBrace;
    text_q.push_back(open_c);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0: add_string();
        1: begin
          if (lvl < 2) add_bracket(is_array, lvl + 1);
          else text_q.push_back(ChComma);
        end
        2: begin
          if (is_array) text_q.push_back($urandom_range(0, 1) ? ChLBrace : ChRBrace);
          else          text_q.push_back($urandom_range(0, 1) ? ChLBrack : ChRBrack);
        end
        default: text_q.push_back(rand_byte_except(ChQuote, open_c, close_c));
      endcase
    end
    text_q.push_back(close_c);
  endfunction

  function automatic void add_array();
    int unsigned n_elem;
    add_ws(2);
    text_q.push_back(ChLBrack);
    n_elem = $urandom_range(0, 5);
    for (int k = 0; k < n_elem; k++) begin
      if (k > 0) begin
        add_ws(1);
        if ($urandom_range(0, 5) == 0) text_q.push_back(ChRBrace);  // stray brace
        text_q.push_back(ChComma);
        add_ws(1);
      end
      case ($urandom_range(0, 3))
        0:       add_string();
        1:       add_bracket(1'b0, 0);
        2:       add_bracket(1'b1, 0);
        default: add_scalar();
      endcase
    end
    add_ws(1);
    text_q.push_back(ChRBrack);
    repeat ($urandom_range(0, 2)) text_q.push_back(ByteW'($urandom_range(0, 255)));
  endfunction

  // mostly well-formed arrays; some cut short, some noise, some non-arrays
  function automatic void make_random_text();
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(0, 9);
    text_q.delete();
    if (pick <= 7) begin
      add_array();
      if (pick == 7) begin
        cut = $urandom_range(1, text_q.size());
        while (text_q.size() > cut) void'(text_q.pop_back());
      end
    end else if (pick == 8) begin
      repeat ($urandom_range(1, 10)) text_q.push_back(ByteW'($urandom_range(0, 255)));
    end else begin
      add_ws(3);
      if ($urandom_range(0, 1)) begin
        text_q.push_back(rand_byte_except(ChLBrack, ChSpace, ChTab));
        repeat ($urandom_range(0, 3)) text_q.push_back(ByteW'($urandom_range(0, 255)));
      end else if (text_q.size() == 0) begin
        text_q.push_back(ChSpace);  // whitespace only
      end
    end
  endfunction

  //--------------------------------------------------------------------------
  // Drivers
  //--------------------------------------------------------------------------
  // sends text_q, tlast on its final byte; tvalid stays up across back-to-back words
  task automatic send_text();
    int unsigned gap;
    for (int i = 0; i < text_q.size(); i++) begin
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= text_q[i];
      s_axis_tlast  <= (i == text_q.size() - 1);
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
    end
    n_texts++;
    n_bytes += text_q.size();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // target index is only changed with the block idle
  task automatic set_target(input logic [TargetW-1:0] idx);
    drain();
    repeat (PipeLatency + 2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= idx;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  //--------------------------------------------------------------------------
  // Main sequence
  //--------------------------------------------------------------------------
  initial begin
    int unsigned rand_bytes;
    int unsigned sel;
    rand_bytes = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed texts, target 0
    set_target(16'd0);
    text_q.delete(); add_str(" \t\r\n[\"a\\\"\",7]"); send_text();   // all ws, escape
    text_q.delete(); add_str("x[1]"); send_text();                   // not an array
    text_q.delete(); add_str("  "); send_text();                     // whitespace only
    text_q.delete();
    add_str("[");
    text_q.push_back(8'h00);                                         // zero byte is data
    text_q.push_back(8'hFF);
    add_str("]ab");                                                  // junk after close
    send_text();
    text_q.delete(); add_str("[\"a\\"); send_text();                 // open string
    text_q.delete(); add_str("[[1"); send_text();                    // open bracket
    text_q.delete(); text_q.push_back(ChLBrack); send_text();        // one-byte text

    // stray braces, quoted and foreign brackets, scalar ended by '}', no close;
    // the sink holds off long enough for the block to stall its input
    set_target(16'd1);
    no_idle     = 1'b1;
    hold_cycles = 80;
    text_q.delete(); add_str("[},{\"]\\\"\":[{}]}}x}[1"); send_text();
    no_idle = 1'b0;

    // top index, never reached by a short array
    set_target(16'hFFFF);
    text_q.delete(); add_str("[1,\"b\",{}]"); send_text();

    // random texts, new target every other text
    while (rand_bytes < RandBytes) begin
      if (n_texts % 2 == 0) begin
        sel = $urandom_range(0, 9);
        if (sel <= 6)      set_target(TargetW'($urandom_range(0, 4)));
        else if (sel == 7) set_target(16'hFFFF);
        else if (sel == 8) set_target(16'd0);
        else               set_target(TargetW'($urandom_range(0, 65535)));
      end
      make_random_text();
      no_idle = ($urandom_range(0, 3) == 0);
      rand_bytes += text_q.size();
      send_text();
    end

    drain();
    repeat (PipeLatency + 8) @(posedge clk_i);
    $display("Ran %0d texts (%0d bytes) over %0d target settings incl. 0 and 65535,",
             n_texts, n_bytes, n_settings);
    $display("with a long receiver hold-off; %0d result words checked, %0d element bytes.",
             checked, emitted);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
